[design/pwvm_pkg.sv]
// ============================================================================
// pwvm_pkg - shared types and constants for the wavetable voice mixer
// Command codes, transfer payloads, controller/datapath handshake structs and
// the note step generator evaluated at elaboration time.
// ============================================================================
package pwvm_pkg;

    localparam int VOICES_DEF     = 8;
    localparam int WAVE_LEN_DEF   = 256;
    localparam int WAVEFORMS_DEF  = 4;

    localparam int FRAC_BITS      = 10;
    localparam int NOTES          = 128;
    localparam int WAVE_SEL_CODES = 256;

    // command codes; 5..7 are no-ops
    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_NOTE_ON  = 3'd1;
    localparam logic [2:0] CMD_NOTE_OFF = 3'd2;
    localparam logic [2:0] CMD_ALL_OFF  = 3'd3;
    localparam logic [2:0] CMD_LOAD     = 3'd4;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FREE  = 2'd1,
        ST_NO_MATCH = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } ctrl_state_t;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_ON,
        OP_OFF
    } scan_op_t;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [6:0]         note;
        logic [7:0]         velocity;
        logic [7:0]         wave_select;
        logic [7:0]         wave_addr;
        logic signed [15:0] wave_value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] mix_sample;
        logic [3:0]         voice_number;
        logic [1:0]         status;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic    capture;
        logic    tick_step;
        logic    on_try;
        logic    off_try;
        logic    clear_all;
        logic    load_wr;
        logic    set_status;
        status_t status_code;
        logic    rsp_load;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] cmd;
        logic       too_big;
        logic       vel_zero;
        logic       free_hit;
        logic       match_hit;
        logic       out_busy;
    } dp_stat_t;

    // 2^(k/12) scaled by 1e12, truncated
    localparam longint unsigned RATIO_ONE = 64'd1000000000000;
    localparam longint unsigned SEMITONE_RATIO [12] = '{
        64'd1000000000000, 64'd1059463094359, 64'd1122462048309, 64'd1189207115002,
        64'd1259921049894, 64'd1334839854170, 64'd1414213562373, 64'd1498307076876,
        64'd1587401051968, 64'd1681792830507, 64'd1781797436280, 64'd1887748625363
    };

    // floor(2^((note-69)/12) * floor(440*wave_len*128/11025)); elaboration only
    function automatic longint unsigned note_step(int note, int wave_len);
        longint unsigned base;
        longint unsigned num;
        int              rel;
        int              oct;
        int              semi;
        base = (64'd440 * 64'(wave_len) * 64'd128) / 64'd11025;
        rel  = note + 3;
        oct  = rel / 12 - 6;
        semi = rel % 12;
        num  = base * SEMITONE_RATIO[semi];
        if (oct >= 0)
        begin
            note_step = (num << oct) / RATIO_ONE;
        end
        else
        begin
            note_step = (num / RATIO_ONE) >> (-oct);
        end
    endfunction

endpackage

[design/pwvm_ctrl.sv]
// ============================================================================
// pwvm_ctrl - command sequencer
// Accepts one command, decodes it and walks the voices one per cycle for
// tick, note on and note off; hands the result to the output register.
// ============================================================================
module pwvm_ctrl #(
    parameter int VOICES = pwvm_pkg::VOICES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  pwvm_pkg::dp_stat_t  stat,
    output pwvm_pkg::dp_cmd_t   cmd,
    output logic [((VOICES > 1) ? $clog2(VOICES) : 1)-1:0] voice_idx
);
    import pwvm_pkg::*;

    localparam int VIdxW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam logic [VIdxW-1:0] LastVoice = VIdxW'(VOICES - 1);

    ctrl_state_t      state_reg, state_next;
    scan_op_t         op_reg, op_next;
    logic [VIdxW-1:0] cnt_reg, cnt_next;
    logic             last;

    assign last      = (cnt_reg == LastVoice);
    assign voice_idx = cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_TICK;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cnt_next   = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_DONE;
                case (stat.cmd)
                    CMD_TICK:
                    begin
                        state_next = S_SCAN;
                        op_next    = OP_TICK;
                    end
                    CMD_NOTE_ON:
                    begin
                        if (!stat.too_big)
                        begin
                            state_next = S_SCAN;
                            op_next    = stat.vel_zero ? OP_OFF : OP_ON;
                        end
                    end
                    CMD_NOTE_OFF:
                    begin
                        if (!stat.too_big)
                        begin
                            state_next = S_SCAN;
                            op_next    = OP_OFF;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SCAN:
            begin
                cnt_next = last ? '0 : cnt_reg + 1'b1;
                case (op_reg)
                    OP_TICK:
                    begin
                        if (last)
                        begin
                            state_next = S_DRAIN;
                        end
                    end
                    OP_ON:
                    begin
                        if (stat.free_hit || last)
                        begin
                            state_next = S_DONE;
                            cnt_next   = '0;
                        end
                    end
                    OP_OFF:
                    begin
                        if (stat.match_hit || last)
                        begin
                            state_next = S_DONE;
                            cnt_next   = '0;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd        = '0;
        cmd.status_code = ST_OK;
        item_stall = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                cmd.capture = item_valid;
            end
            S_DECODE:
            begin
                case (stat.cmd)
                    CMD_NOTE_ON:
                    begin
                        if (stat.too_big)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_NO_FREE;
                        end
                    end
                    CMD_NOTE_OFF:
                    begin
                        if (stat.too_big)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_NO_MATCH;
                        end
                    end
                    CMD_ALL_OFF:
                    begin
                        cmd.clear_all = 1'b1;
                    end
                    CMD_LOAD:
                    begin
                        cmd.load_wr = 1'b1;
                    end
                    default:
                    begin
                        cmd.set_status = 1'b0;
                    end
                endcase
            end
            S_SCAN:
            begin
                case (op_reg)
                    OP_TICK:
                    begin
                        cmd.tick_step = 1'b1;
                    end
                    OP_ON:
                    begin
                        cmd.on_try = 1'b1;
                        if (!stat.free_hit && last)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_NO_FREE;
                        end
                    end
                    OP_OFF:
                    begin
                        cmd.off_try = 1'b1;
                        if (!stat.match_hit && last)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_NO_MATCH;
                        end
                    end
                    default:
                    begin
                        cmd.tick_step = 1'b0;
                    end
                endcase
            end
            S_DONE:
            begin
                cmd.rsp_load = !stat.out_busy;
            end
            default:
            begin
                cmd.capture = 1'b0;
            end
        endcase
    end

    // a voice walk always starts at the first voice
    a_scan_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && $past(state_reg) != S_SCAN) |-> cnt_reg == '0)
        else $error("voice walk did not start at voice zero");

endmodule

[design/pwvm_dp.sv]
// ============================================================================
// pwvm_dp - voice state, wavetable memory, mixer and output register
// Executes one sequencer command per cycle; reports hits and output status.
// ============================================================================
module pwvm_dp #(
    parameter int VOICES    = pwvm_pkg::VOICES_DEF,
    parameter int WAVE_LEN  = pwvm_pkg::WAVE_LEN_DEF,
    parameter int WAVEFORMS = pwvm_pkg::WAVEFORMS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pwvm_pkg::in_item_t   item,
    input  pwvm_pkg::dp_cmd_t    cmd,
    input  logic [((VOICES > 1) ? $clog2(VOICES) : 1)-1:0] voice_idx,
    output pwvm_pkg::dp_stat_t   stat,
    output logic                 result_valid,
    input  logic                 result_stall,
    output pwvm_pkg::out_item_t  result
);
    import pwvm_pkg::*;

    localparam int VIdxW    = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int SpanI    = WAVE_LEN * (1 << FRAC_BITS);
    localparam int StepW    = $clog2(SpanI);
    localparam int PhaseW   = StepW + 1;
    localparam int IdxW     = StepW - FRAC_BITS;
    localparam int WaveW    = (WAVEFORMS > 1) ? $clog2(WAVEFORMS) : 1;
    localparam int MemDepth = WAVEFORMS * WAVE_LEN;
    localparam int AddrW    = $clog2(MemDepth);
    localparam logic [PhaseW-1:0] Span = PhaseW'(SpanI);

    // note step table: {too large, step}
    logic [StepW:0]   step_rom [NOTES];
    logic [WaveW-1:0] wsel_mod [WAVE_SEL_CODES];

    for (genvar g = 0; g < NOTES; g++)
    begin : g_rom
        localparam longint unsigned StepVal = note_step(g, WAVE_LEN);
        assign step_rom[g] = (StepVal >= 64'(SpanI)) ? {1'b1, StepW'(0)}
                                                     : {1'b0, StepW'(StepVal)};
    end

    for (genvar g = 0; g < WAVE_SEL_CODES; g++)
    begin : g_wmod
        assign wsel_mod[g] = WaveW'(g % WAVEFORMS);
    end

    // latched command
    logic [2:0]         cmd_reg;
    logic               too_big_reg;
    logic [StepW-1:0]   step_reg;
    logic               vel_zero_reg;
    logic [WaveW-1:0]   wsel_reg;
    logic [7:0]         addr_reg;
    logic signed [15:0] value_reg;

    // voices
    logic [PhaseW-1:0]  phase_reg [VOICES];
    logic [StepW-1:0]   vstep_reg [VOICES];
    logic [WaveW-1:0]   vwave_reg [VOICES];
    logic [VOICES-1:0]  active_reg;

    // wavetable and mixer
    logic signed [15:0] wave_mem [MemDepth];
    logic signed [15:0] rd_data_reg;
    logic               rd_valid_reg;
    logic signed [31:0] sum_reg;
    logic [3:0]         voice_reg;
    status_t            status_reg;
    out_item_t          out_reg;
    logic               out_valid_reg, out_valid_next;

    logic [PhaseW-1:0]  phase_cur;
    logic [StepW-1:0]   wrapped;
    logic [IdxW-1:0]    rd_idx;
    logic [AddrW-1:0]   rd_addr;
    logic [AddrW-1:0]   wr_addr;
    logic               addr_ok;
    logic               free_hit;
    logic               match_hit;
    logic               tick_rd;

    assign phase_cur = phase_reg[voice_idx];
    assign wrapped   = (phase_cur >= Span) ? StepW'(phase_cur - Span) : phase_cur[StepW-1:0];
    assign rd_idx    = wrapped[StepW-1:FRAC_BITS];
    assign rd_addr   = AddrW'(int'(vwave_reg[voice_idx]) * WAVE_LEN + int'(rd_idx));
    assign addr_ok   = int'(addr_reg) < WAVE_LEN;
    assign wr_addr   = AddrW'(int'(wsel_reg) * WAVE_LEN + int'(addr_reg));
    assign free_hit  = !active_reg[voice_idx];
    assign match_hit = active_reg[voice_idx] && (vstep_reg[voice_idx] == step_reg);
    assign tick_rd   = cmd.tick_step && active_reg[voice_idx];

    assign stat.cmd       = cmd_reg;
    assign stat.too_big   = too_big_reg;
    assign stat.vel_zero  = vel_zero_reg;
    assign stat.free_hit  = free_hit;
    assign stat.match_hit = match_hit;
    assign stat.out_busy  = out_valid_reg && result_stall;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg      <= item.cmd;
            {too_big_reg, step_reg} <= step_rom[item.note];
            vel_zero_reg <= (item.velocity == 8'd0);
            wsel_reg     <= wsel_mod[item.wave_select];
            addr_reg     <= item.wave_addr;
            value_reg    <= item.wave_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_rd)
        begin
            phase_reg[voice_idx] <= PhaseW'(wrapped) + PhaseW'(vstep_reg[voice_idx]);
        end
        if (cmd.on_try && free_hit)
        begin
            phase_reg[voice_idx] <= '0;
            vstep_reg[voice_idx] <= step_reg;
            vwave_reg[voice_idx] <= wsel_reg;
        end
        if (cmd.off_try && match_hit)
        begin
            phase_reg[voice_idx] <= '0;
        end
        if (cmd.clear_all)
        begin
            for (int v = 0; v < VOICES; v++)
            begin
                phase_reg[v] <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_all)
            begin
                active_reg <= '0;
            end
            else if (cmd.on_try && free_hit)
            begin
                active_reg[voice_idx] <= 1'b1;
            end
            else if (cmd.off_try && match_hit)
            begin
                active_reg[voice_idx] <= 1'b0;
            end
            rd_valid_reg  <= tick_rd;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && result_stall;
        if (cmd.rsp_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && addr_ok)
        begin
            wave_mem[wr_addr] <= value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_rd)
        begin
            rd_data_reg <= wave_mem[rd_addr];
        end
    end

    // mixer accumulates one sample behind the address
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sum_reg    <= '0;
            voice_reg  <= 4'd0;
            status_reg <= ST_OK;
        end
        else
        begin
            if (rd_valid_reg)
            begin
                sum_reg <= sum_reg + {{4{rd_data_reg[15]}}, rd_data_reg, 12'd0};
            end
            if ((cmd.on_try && free_hit) || (cmd.off_try && match_hit))
            begin
                voice_reg <= 4'(voice_idx) + 4'd1;
            end
            if (cmd.set_status)
            begin
                status_reg <= cmd.status_code;
            end
        end
        if (cmd.rsp_load)
        begin
            out_reg.mix_sample   <= sum_reg;
            out_reg.voice_number <= voice_reg;
            out_reg.status       <= status_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rsp_load |-> !(out_valid_reg && result_stall))
        else $error("result register overwritten while held");

    a_claim_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.on_try && free_hit) |=> active_reg[$past(voice_idx)])
        else $error("claimed voice not active");

    a_fail_no_voice: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.status == ST_OK || out_reg.voice_number == 4'd0))
        else $error("failed command reports a voice");

endmodule

[design/polyphonic_wavetable_voice_mixer.sv]
// ============================================================================
// polyphonic_wavetable_voice_mixer - polyphonic wavetable synthesizer
// Command sequencer plus voice/wavetable datapath with a registered result.
// ============================================================================
// Usage:
//   Commands enter on the item channel (item_valid / item_stall / item); a
//   transfer happens on a rising edge with item_valid high and item_stall low.
//   Every command yields exactly one result on the result channel
//   (result_valid / result_stall / result).
//   Each command is first decoded. A tick walks every voice and then drains
//   the last wavetable read; note on / off walk the voices until a free or
//   matching voice or the last one (a note with no valid step skips the walk);
//   other commands skip the walk. The walk takes one voice per cycle through
//   the single read port of the wavetable memory.
//   The result is registered and becomes valid as the sequencer leaves its
//   done state.
//   The result sits in an output register, so the next command is accepted
//   while a result waits; a stalled receiver holds the result stable and the
//   sequencer waits only when a second result is ready before the first
//   transfer.
//   Reset (rst_n low, asynchronous) marks every voice inactive and empties
//   the output register. Wavetables are not cleared: load every entry a
//   voice will play before starting it.
// ============================================================================
module polyphonic_wavetable_voice_mixer #(
    parameter int VOICES    = pwvm_pkg::VOICES_DEF,
    parameter int WAVE_LEN  = pwvm_pkg::WAVE_LEN_DEF,
    parameter int WAVEFORMS = pwvm_pkg::WAVEFORMS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  pwvm_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_stall,
    output pwvm_pkg::out_item_t result
);
    import pwvm_pkg::*;

    localparam int VIdxW = (VOICES > 1) ? $clog2(VOICES) : 1;

    dp_cmd_t          dp_cmd;     // sequencer commands
    dp_stat_t         dp_stat;    // datapath status back to the sequencer
    logic [VIdxW-1:0] voice_idx;  // voice under work during a walk

    pwvm_ctrl #(
        .VOICES (VOICES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .stat       (dp_stat),
        .cmd        (dp_cmd),
        .voice_idx  (voice_idx)
    );

    pwvm_dp #(
        .VOICES    (VOICES),
        .WAVE_LEN  (WAVE_LEN),
        .WAVEFORMS (WAVEFORMS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (dp_cmd),
        .voice_idx    (voice_idx),
        .stat         (dp_stat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
